FILE: hdl/tmcp_pkg.sv
// Package for the triangular matrix chain product block.
// Holds channel payload types and state codes; no dependencies.
`default_nettype none
package tmcp_pkg;
	localparam int MODE_LOAD = 0;
	localparam int MODE_ROW  = 1;

	typedef struct packed {
		logic        mode;
		logic [5:0]  row;
		logic [5:0]  col;
		logic signed [15:0] a_value;
		logic signed [15:0] b_value;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [5:0]  out_col;
		logic        last;
	} out_item_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_AB   = 6'b000010,
		ST_ABB  = 6'b000100,
		ST_ATA  = 6'b001000,
		ST_OUT  = 6'b010000,
		ST_WAIT = 6'b100000
	} state_t;
endpackage
`default_nettype wire

FILE: hdl/tmcp_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on tmcp_pkg.
`default_nettype none
interface tmcp_in_if import tmcp_pkg::*; ;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tmcp_out_if import tmcp_pkg::*; ;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/triangular_matrix_chain_product.sv
// Top level: C = A*B*B^T + A^T*A row server with one shared MAC.
// Depends on tmcp_pkg and tmcp_if.
//
// channel   dir  handshake    payload
// in_ch     in   valid/ready  mode,row,col,a_value,b_value
// out_ch    out  valid/ready  value,out_col,last
// cfg       in   cfg_we       cfg_data = matrix_size
//
// Load: an item is written to the stores as it is taken. Row request: n*(n-r)
// + n*n + sum over j of (min(r,j)+1) MAC steps, each an address phase, then
// registered read data; the single multiply-accumulate unit and the one read
// port per store set this pacing. Worst case is row 0, with the most MAC steps.
// Each result waits in the output register until taken; input is not ready
// during a row request. Reset clears control only; stores are undefined until
// written.
`default_nettype none
module triangular_matrix_chain_product import tmcp_pkg::*; #(
	parameter int MAX_SIZE  = 64,
	parameter int ELEM_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [6:0] cfg_data,
	tmcp_in_if.sink   in_ch,
	tmcp_out_if.source out_ch
);
	localparam int IW = $clog2(MAX_SIZE);
	localparam int AW = 2 * IW;
	localparam int NW = IW + 1;

	logic [6:0] size_q;
	logic [NW-1:0] n;
	always_comb begin
		if (size_q == 7'd0) n = NW'(1);
		else if (32'(size_q) > MAX_SIZE) n = NW'(MAX_SIZE);
		else n = NW'(size_q);
	end

	// stores
	logic signed [ELEM_BITS-1:0] a_mem [MAX_SIZE*MAX_SIZE];
	logic signed [ELEM_BITS-1:0] b_mem [MAX_SIZE*MAX_SIZE];
	logic signed [37:0] ab_mem [MAX_SIZE*MAX_SIZE];

	state_t state_q;
	logic [IW-1:0] r_q, j_q, k_q;
	logic ph_q;                          // 0: address issued, 1: data valid
	logic signed [63:0] acc_q;
	logic a_zero_q, b_zero_q;

	// memory ports
	logic [AW-1:0] a_addr, b_addr, ab_addr;
	logic signed [ELEM_BITS-1:0] a_rd_q, b_rd_q;
	logic signed [37:0] ab_rd_q;
	logic ab_we;
	logic load_fire;
	assign load_fire = in_ch.valid && in_ch.ready && in_ch.data.mode == 1'(MODE_LOAD)
		&& 32'(in_ch.data.row) < MAX_SIZE && 32'(in_ch.data.col) < MAX_SIZE;

	always_comb begin
		a_addr = {in_ch.data.row[IW-1:0], in_ch.data.col[IW-1:0]};
		b_addr = a_addr;
		ab_addr = {r_q, k_q};
		unique case (state_q)
			ST_AB: begin
				a_addr = {r_q, k_q};
				b_addr = {k_q, j_q};
			end
			ST_ABB: b_addr = {j_q, k_q};
			ST_ATA: begin
				a_addr = {k_q, r_q};
				b_addr = {k_q, j_q};
			end
			default: ;
		endcase
	end

	// ATA reuses the b read port on a copy of A: second A port by duplicate
	logic signed [ELEM_BITS-1:0] a2_mem [MAX_SIZE*MAX_SIZE];
	logic signed [ELEM_BITS-1:0] a2_rd_q;

	// multiplier operands after the read register
	logic signed [37:0] op_x;
	logic signed [ELEM_BITS-1:0] op_y;
	logic signed [63:0] prod;
	logic signed [63:0] acc_sum;
	always_comb begin
		op_x = 38'(a_rd_q);
		op_y = b_rd_q;
		unique case (state_q)
			ST_AB:  begin
				op_x = a_zero_q ? 38'sd0 : 38'(a_rd_q);
			end
			ST_ABB: op_x = ab_rd_q;
			ST_ATA: begin
				op_x = 38'(a_rd_q);
				op_y = b_zero_q ? '0 : a2_rd_q;
			end
			default: ;
		endcase
		prod = 64'(op_x) * 64'(op_y);
	end
	assign acc_sum = acc_q + prod;

	always_ff @(posedge clk) begin
		if (load_fire) begin
			a_mem[a_addr]  <= in_ch.data.a_value[ELEM_BITS-1:0];
			a2_mem[a_addr] <= in_ch.data.a_value[ELEM_BITS-1:0];
			b_mem[b_addr]  <= in_ch.data.b_value[ELEM_BITS-1:0];
		end
		a_rd_q  <= a_mem[a_addr];
		a2_rd_q <= a2_mem[b_addr];
		b_rd_q  <= b_mem[b_addr];
		// last product of the column goes in with the sum
		if (ab_we) ab_mem[{r_q, j_q}] <= acc_sum[37:0];
		ab_rd_q <= ab_mem[ab_addr];
	end

	logic [IW-1:0] lim;
	assign lim = (r_q < j_q) ? r_q : j_q;
	logic last_k;
	logic out_busy;
	logic out_load;
	assign out_busy = out_ch.valid && !out_ch.ready;
	assign out_load = (state_q == ST_OUT) && !out_busy;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign ab_we = (state_q == ST_AB) && ph_q && NW'(k_q) == n - NW'(1);

	always_comb begin
		unique case (state_q)
			ST_ATA:  last_k = (k_q == lim);
			default: last_k = NW'(k_q) == n - NW'(1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 7'd64;
			state_q <= ST_IDLE;
			out_ch.valid <= 1'b0;
			out_ch.data <= '0;
			ph_q <= 1'b0;
			r_q <= '0;
			j_q <= '0;
			k_q <= '0;
			acc_q <= '0;
			a_zero_q <= 1'b0;
			b_zero_q <= 1'b0;
		end else begin
			if (cfg_we) size_q <= cfg_data;
			if (out_load) out_ch.valid <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.data.mode == 1'(MODE_ROW)
						&& NW'(in_ch.data.row) < n
						&& 32'(in_ch.data.row) < MAX_SIZE) begin
						r_q <= in_ch.data.row[IW-1:0];
						j_q <= '0;
						k_q <= in_ch.data.row[IW-1:0];
						acc_q <= '0;
						ph_q <= 1'b0;
						state_q <= ST_AB;
					end
				end
				ST_AB: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
						a_zero_q <= 1'b0;
					end else begin
						// data for k is here; column done clears the sum
						ph_q <= 1'b0;
						if (last_k) begin
							acc_q <= '0;
							if (NW'(j_q) == n - NW'(1)) begin
								j_q <= '0;
								k_q <= '0;
								state_q <= ST_ABB;
							end else begin
								j_q <= j_q + 1'b1;
								k_q <= r_q;
							end
						end else begin
							acc_q <= acc_sum;
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_ABB: begin
					if (!ph_q) ph_q <= 1'b1;
					else begin
						acc_q <= acc_sum;
						ph_q <= 1'b0;
						if (last_k) begin
							k_q <= '0;
							state_q <= ST_ATA;
						end else k_q <= k_q + 1'b1;
					end
				end
				ST_ATA: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
						b_zero_q <= 1'b0;
					end else begin
						acc_q <= acc_sum;
						ph_q <= 1'b0;
						if (last_k) state_q <= ST_OUT;
						else k_q <= k_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (!out_busy) begin
						out_ch.data.value <= acc_q;
						out_ch.data.out_col <= 6'(j_q);
						out_ch.data.last <= NW'(j_q) == n - NW'(1);
						acc_q <= '0;
						k_q <= '0;
						if (NW'(j_q) == n - NW'(1)) state_q <= ST_WAIT;
						else begin
							j_q <= j_q + 1'b1;
							state_q <= ST_ABB;
						end
					end
				end
				ST_WAIT: begin
					if (!out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Triangle: in AB, k >= r always so a_at(r,k) is stored; in ATA, k <= lim
	// keeps both reads on or above the diagonal. Zero flags stay clear.

	property p_ready_idle;
		@(posedge clk) disable iff (!arst_n) in_ch.ready |-> state_q == ST_IDLE;
	endproperty
	a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result lost");

	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> NW'(j_q) < n)
		else $error("column out of range");

	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		ab_we |-> state_q == ST_AB && ph_q)
		else $error("bad ab write");
endmodule
`default_nettype wire
